>>> hdl/assert_macros.svh
// assertion macros shared by the intersect engine modules
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/spli_pkg.sv
// types and constants of the sorted posting list intersect engine
// no dependencies; used by every module of the block
package spli_pkg;

  localparam int SET_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(SET_DEPTH);
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int DOC_W     = 24;
  localparam int TOK_W     = 20;
  localparam int KEY_W     = DOC_W + TOK_W;

  localparam logic REQ_ELEM   = 1'b0;
  localparam logic REQ_ABSENT = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [DOC_W-1:0] doc_id;
    logic [TOK_W-1:0] token_pos;
    logic             list_end;
    logic             query_end;
  } in_item_t;

  typedef struct packed {
    logic [DOC_W-1:0] hit_doc;
    logic [TOK_W-1:0] hit_token;
    logic             no_hit;
    logic             final_flag;
    logic             overflow;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic store;
    logic step;
    logic hit;
    logic finish;
    logic match;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic absent;
    logic live;
    logic first;
    logic room;
    logic scan_ok;
    logic scan_next_ok;
    logic lt;
    logic eq;
    logic qend;
    logic final_item;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/spli_ctrl.sv
// controller state machine of the intersect engine
// depends on spli_pkg and assert_macros.svh
`include "assert_macros.svh"

module spli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spli_pkg::sts_t sts_i,
  output spli_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0] state_q, state_d;
  logic       match_q, match_d;
  logic       done;
  logic       m;
  logic       emit;

  always_comb begin
    state_d = state_q;
    match_d = match_q;
    cmd_o   = '0;
    done    = 1'b0;
    m       = 1'b0;
    emit    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.absent || !sts_i.live) begin
          done = 1'b1;
        end else if (sts_i.first) begin
          cmd_o.store = 1'b1;
          m           = sts_i.room;
          done        = 1'b1;
        end else if (sts_i.scan_ok) begin
          state_d = S_CMP;
        end else begin
          done = 1'b1;
        end
      end
      S_CMP: begin
        if (sts_i.lt) begin
          cmd_o.step = 1'b1;
          if (!sts_i.scan_next_ok) begin
            done = 1'b1;
          end
        end else if (sts_i.eq) begin
          cmd_o.hit = 1'b1;
          m         = 1'b1;
          done      = 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      S_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.match  = match_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (done) begin
      emit = (m && sts_i.qend) || sts_i.final_item;
      if (emit && !sts_i.out_free) begin
        match_d = m;
        state_d = S_HOLD;
      end else begin
        cmd_o.finish = 1'b1;
        cmd_o.match  = m;
        state_d      = S_IDLE;
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      match_q <= 1'b0;
    end else begin
      state_q <= state_d;
      match_q <= match_d;
    end
  end

  `ASSERT_NXT(a_accept_to_exec, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_EXEC)
  `ASSERT_IMP(a_write_ends_item, clk_i, rst_ni, cmd_o.hit || cmd_o.store, cmd_o.finish || state_d == S_HOLD)
  `ASSERT_IMP(a_cmp_entry, clk_i, rst_ni, state_q == S_CMP, $past(state_q) == S_EXEC || $past(state_q) == S_CMP)

endmodule

>>> hdl/spli_dp.sv
// datapath of the intersect engine: item register, ping-pong set memory,
// query counters and output register; depends on spli_pkg and assert_macros.svh
`include "assert_macros.svh"

module spli_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spli_pkg::in_item_t  in_item_i,
  input  spli_pkg::cmd_t      cmd_i,
  output spli_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spli_pkg::out_item_t out_item_o
);

  localparam logic [spli_pkg::CNT_W-1:0] DEPTH_C = spli_pkg::CNT_W'(spli_pkg::SET_DEPTH);
  localparam logic [spli_pkg::CNT_W-1:0] ONE_C   = spli_pkg::CNT_W'(1);

  logic [spli_pkg::KEY_W-1:0] set_mem_q [2*spli_pkg::SET_DEPTH];

  spli_pkg::in_item_t         item_q;
  spli_pkg::out_item_t        out_q, out_d;
  logic                       out_valid_q, out_valid_d;
  logic [spli_pkg::KEY_W-1:0] rdata_q;
  logic                       bank_q, bank_d;
  logic [spli_pkg::CNT_W-1:0] held_q, held_d;
  logic [spli_pkg::CNT_W-1:0] new_q, new_d;
  logic [spli_pkg::CNT_W-1:0] scan_q, scan_d;
  logic                       first_q, first_d;
  logic                       empty_q, empty_d;
  logic                       ovf_q, ovf_d;

  logic [spli_pkg::KEY_W-1:0] key;
  logic                       absent;
  logic                       lend;
  logic                       final_item;
  logic                       room;
  logic                       new_room;
  logic                       out_free;
  logic [spli_pkg::CNT_W-1:0] scan_inc;
  logic                       store_ok;
  logic                       hit_ok;
  logic [spli_pkg::CNT_W-1:0] held_e;
  logic [spli_pkg::CNT_W-1:0] new_e;
  logic                       empty_e;
  logic                       ovf_e;
  logic                       hit;
  logic                       wr_en;
  logic [spli_pkg::ADDR_W:0]  wr_addr;
  logic [spli_pkg::ADDR_W:0]  rd_addr;

  assign key        = {item_q.doc_id, item_q.token_pos};
  assign absent     = (item_q.req_type == spli_pkg::REQ_ABSENT);
  assign lend       = item_q.list_end || absent;
  assign final_item = lend && item_q.query_end;
  assign room       = (held_q < DEPTH_C);
  assign new_room   = (new_q < DEPTH_C);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign scan_inc   = scan_q + ONE_C;

  always_comb begin
    sts_o              = '0;
    sts_o.absent       = absent;
    sts_o.live         = !empty_q;
    sts_o.first        = first_q;
    sts_o.room         = room;
    sts_o.scan_ok      = (scan_q < held_q);
    sts_o.scan_next_ok = (scan_inc < held_q);
    sts_o.lt           = (rdata_q < key);
    sts_o.eq           = (rdata_q == key);
    sts_o.qend         = item_q.query_end;
    sts_o.final_item   = final_item;
    sts_o.out_free     = out_free;
  end

  assign store_ok = cmd_i.store && room;
  assign hit_ok   = cmd_i.hit && new_room;
  assign held_e   = held_q + spli_pkg::CNT_W'(store_ok);
  assign new_e    = new_q + spli_pkg::CNT_W'(hit_ok);
  assign empty_e  = empty_q || (cmd_i.finish && absent);
  assign ovf_e    = ovf_q || (cmd_i.store && !room);
  assign hit      = cmd_i.match && item_q.query_end;

  always_comb begin
    bank_d  = bank_q;
    held_d  = held_e;
    new_d   = new_e;
    scan_d  = (cmd_i.step || cmd_i.hit) ? scan_inc : scan_q;
    first_d = first_q;
    empty_d = empty_e;
    ovf_d   = ovf_e;
    if (cmd_i.finish) begin
      if (final_item) begin
        held_d  = '0;
        new_d   = '0;
        scan_d  = '0;
        first_d = 1'b1;
        empty_d = 1'b0;
        ovf_d   = 1'b0;
      end else if (lend) begin
        if (!empty_e && !first_q) begin
          held_d = new_e;
          bank_d = ~bank_q;
          if (new_e == '0) begin
            empty_d = 1'b1;
          end
        end
        first_d = 1'b0;
        new_d   = '0;
        scan_d  = '0;
      end
    end
  end

  // result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.finish && (hit || final_item)) begin
      out_d.hit_doc    = hit ? item_q.doc_id : '0;
      out_d.hit_token  = hit ? item_q.token_pos : '0;
      out_d.no_hit     = !hit;
      out_d.final_flag = final_item;
      out_d.overflow   = ovf_e;
      out_valid_d      = 1'b1;
    end
  end

  // one write port shared by first-list store and merge survivors
  assign wr_en   = store_ok || hit_ok;
  assign wr_addr = store_ok ? {bank_q, held_q[spli_pkg::ADDR_W-1:0]}
                            : {~bank_q, new_q[spli_pkg::ADDR_W-1:0]};
  assign rd_addr = {bank_q, scan_d[spli_pkg::ADDR_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      set_mem_q[wr_addr] <= key;
    end
    rdata_q <= set_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bank_q      <= 1'b0;
      held_q      <= '0;
      new_q       <= '0;
      scan_q      <= '0;
      first_q     <= 1'b1;
      empty_q     <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      bank_q      <= bank_d;
      held_q      <= held_d;
      new_q       <= new_d;
      scan_q      <= scan_d;
      first_q     <= first_d;
      empty_q     <= empty_d;
      ovf_q       <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_IMP(a_held_in_range, clk_i, rst_ni, 1'b1, held_q <= DEPTH_C)
  `ASSERT_IMP(a_scan_below_held, clk_i, rst_ni, 1'b1, scan_q <= held_q)
  `ASSERT_IMP(a_new_below_scan, clk_i, rst_ni, 1'b1, new_q <= scan_q)

endmodule

>>> hdl/sorted_posting_list_intersect_top.sv
// Multi-term AND query engine over sorted posting lists, one location item at a time.
// The first term's list is stored (up to SET_DEPTH locations, the rest dropped and
// flagged); each later list is merge-intersected against the stored set into the other
// half of a ping-pong memory, and matches of the query's last term are sent out as
// found, with a final result closing every query. An item is accepted, then decided
// without a merge scan for first-term items, absent-term markers and items after the
// answer has gone empty. A merge item instead compares stored entries in turn, since
// the scan reads one stored location per cycle from the single read port of the set
// memory; over a whole list the scan passes over each stored entry at most once. A
// result that cannot enter a full output register adds the wait for it. No memory
// clearing pass follows reset.
// Depends on spli_pkg, spli_ctrl and spli_dp.
module sorted_posting_list_intersect_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spli_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spli_pkg::out_item_t out_item_o
);

  spli_pkg::cmd_t cmd;
  spli_pkg::sts_t sts;

  spli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spli_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
